// ===== hw/rtl/bnbc_pkg.sv =====
// Package for the binned naive Bayes classifier core.
// Holds the controller state type, score width and the Q8 log2 and score saturation helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bnbc_pkg;

  localparam int SCORE_W = 24;
  localparam int LOG_W = 16;
  localparam logic signed [LOG_W-1:0] LOG_OF_ZERO = -16'sd3402;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE,
    S_ARGMAX
  } state_t;

  // Mitchell log2 in Q8; zero maps to the log of a small probability.
  function automatic logic signed [LOG_W-1:0] log2_q8(input logic [31:0] x);
    logic [4:0] k;
    logic [39:0] shifted;
    logic [7:0] frac;
    k = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (x[i]) begin
        k = 5'(i);
      end
    end
    shifted = {x, 8'd0} >> k;
    frac = shifted[7:0];
    if (x == 32'd0) begin
      log2_q8 = LOG_OF_ZERO;
    end else begin
      log2_q8 = $signed({3'd0, k, frac});
    end
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SCORE_W:0] s);
    if (s > $signed({SCORE_MAX[SCORE_W-1], SCORE_MAX})) begin
      sat_score = SCORE_MAX;
    end else if (s < $signed({SCORE_MIN[SCORE_W-1], SCORE_MIN})) begin
      sat_score = SCORE_MIN;
    end else begin
      sat_score = s[SCORE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/binned_naive_bayes_classifier_core.sv =====
// Top level of the binned naive Bayes classifier: controller, score lanes, argmax.
// Depends on bnbc_pkg and bnbc_count_mem.
//
// Channel | Dir | Fields (low bit first)
// in_     | in  | tdata: pixel_value[7:0], pixel_index[17:8], image_label[21:18];
//         |     | tuser: operation; tlast: last_pixel
// out_    | out | tdata: predicted_label[3:0], best_score[27:4]; tuser: no_model
// cfg_    | in  | wdata: pixels_per_image[10:0]
//
// Each pixel gets a count memory row read when accepted, then a read-modify-write.
// The last classification pixel then starts an argmax pass that steps through the classes in order.
// After reset a clearing pass over all 2^(clog2(MAX_PIXELS)+clog2(NUM_BINS)) rows
// (32768 by default) zeroes the count memory; in_tready stays low meanwhile.
// A finished result waiting on out_tready stalls only the end of the next argmax.
`timescale 1ns / 1ps
`default_nettype none
module binned_naive_bayes_classifier_core
  import bnbc_pkg::*;
#(
  parameter int NUM_CLASSES = 10,
  parameter int NUM_BINS = 32,
  parameter int MAX_PIXELS = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // pixel_value, pixel_index, image_label
  input  wire logic        in_tuser,  // operation
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata, // predicted_label, best_score
  output logic             out_tuser, // no_model
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata
);

  localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int ADDR_W = PIX_W + BIN_W;
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int ROW_W = NUM_CLASSES * COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef logic [NUM_CLASSES-1:0][COUNT_WIDTH-1:0] row_t;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [10:0] ppi_r;
  logic op_r, last_r, in_range_r;
  logic [3:0] label_r;
  logic [ADDR_W-1:0] addr_r;
  logic [COUNT_WIDTH-1:0] img_r [NUM_CLASSES];
  logic signed [SCORE_W-1:0] score_r [NUM_CLASSES];
  logic [CW-1:0] cls_r, cls_nxt;
  logic found_r, found_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic signed [SCORE_W-1:0] best_sc_r, best_sc_nxt;
  logic out_valid_r;
  logic [3:0] out_label_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic out_nomodel_r;

  logic accept, out_free, finish;
  logic [31:0] idx32;
  logic [15:0] bin_prod;
  logic [7:0] bin_raw;
  logic [BIN_W-1:0] bin_sel;
  logic [ADDR_W-1:0] rd_addr;
  logic rd_range;
  row_t rd_row, wr_row;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic label_ok;
  logic signed [SCORE_W-1:0] final_sc;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;
  assign label_ok = ({28'd0, label_r} < NUM_CLASSES);

  assign idx32 = {22'd0, in_tdata[17:8]};
  assign bin_prod = 16'(in_tdata[7:0]) * 16'(NUM_BINS);
  assign bin_raw = bin_prod[15:8];
  assign bin_sel = ({24'd0, bin_raw} >= NUM_BINS) ? BIN_W'(NUM_BINS - 1) : bin_raw[BIN_W-1:0];
  assign rd_addr = {idx32[PIX_W-1:0], bin_sel};
  assign rd_range = (in_tdata[17:8] < ppi_r[9:0] || ppi_r[10]) && (idx32 < MAX_PIXELS);

  bnbc_count_mem #(
    .ADDR_W(ADDR_W),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk  (clk),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rd_row),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(wr_row)
  );

  always_comb begin
    wr_row = rd_row;
    mem_we = 1'b0;
    mem_waddr = addr_r;
    if (state_r == S_CLEAR) begin
      wr_row = '0;
      mem_we = 1'b1;
      mem_waddr = clr_addr_r;
    end else if (state_r == S_UPDATE && !op_r && label_ok && in_range_r) begin
      mem_we = 1'b1;
      if (rd_row[label_r[CW-1:0]] != CNT_MAX) begin
        wr_row[label_r[CW-1:0]] = rd_row[label_r[CW-1:0]] + 1'b1;
      end
    end
  end

  assign final_sc = sat_score($signed({score_r[cls_r][SCORE_W-1], score_r[cls_r]})
                    + (SCORE_W + 1)'(log2_q8(32'(img_r[cls_r]))));
  assign finish = (state_r == S_ARGMAX) && ({{(32 - CW){1'b0}}, cls_r} == NUM_CLASSES - 1)
                  && out_free;

  always_comb begin
    state_nxt = state_r;
    clr_addr_nxt = clr_addr_r;
    cls_nxt = cls_r;
    found_nxt = found_r;
    best_nxt = best_r;
    best_sc_nxt = best_sc_r;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cls_nxt = '0;
        found_nxt = 1'b0;
        best_nxt = '0;
        best_sc_nxt = '0;
        state_nxt = (op_r && last_r) ? S_ARGMAX : S_IDLE;
      end
      S_ARGMAX: begin
        if (img_r[cls_r] != '0 && (!found_r || final_sc > best_sc_r)) begin
          found_nxt = 1'b1;
          best_nxt = cls_r;
          best_sc_nxt = final_sc;
        end
        if ({{(32 - CW){1'b0}}, cls_r} != NUM_CLASSES - 1) begin
          cls_nxt = cls_r + 1'b1;
        end else if (out_free) begin
          state_nxt = S_IDLE;
          found_nxt = found_r;
          best_nxt = best_r;
          best_sc_nxt = best_sc_r;
        end else begin
          found_nxt = found_r;
          best_nxt = best_r;
          best_sc_nxt = best_sc_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_addr_r <= '0;
      ppi_r <= 11'd784;
      cls_r <= '0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cls_r <= cls_nxt;
      found_r <= found_nxt;
      if (cfg_we) begin
        ppi_r <= cfg_wdata;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    best_sc_r <= best_sc_nxt;
    if (accept) begin
      op_r <= in_tuser;
      last_r <= in_tlast;
      label_r <= in_tdata[21:18];
      in_range_r <= rd_range;
      addr_r <= rd_addr;
    end
    if (finish) begin
      if (img_r[cls_r] != '0 && (!found_r || final_sc > best_sc_r)) begin
        out_label_r <= 4'(cls_r);
        out_score_r <= final_sc;
        out_nomodel_r <= 1'b0;
      end else begin
        out_label_r <= 4'(best_r);
        out_score_r <= best_sc_r;
        out_nomodel_r <= !found_r;
      end
    end
  end

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
    logic signed [LOG_W-1:0] diff;
    assign diff = log2_q8(32'(rd_row[c])) - log2_q8(32'(img_r[c]));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        img_r[c] <= '0;
        score_r[c] <= '0;
      end else if (finish) begin
        score_r[c] <= '0;
      end else if (state_r == S_UPDATE) begin
        if (!op_r && last_r && label_ok && label_r[CW-1:0] == CW'(c)
            && img_r[c] != CNT_MAX) begin
          img_r[c] <= img_r[c] + 1'b1;
        end
        if (op_r && in_range_r && img_r[c] != '0) begin
          score_r[c] <= sat_score($signed({score_r[c][SCORE_W-1], score_r[c]})
                                  + (SCORE_W + 1)'(diff));
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'd0, out_score_r, out_label_r};
  assign out_tuser = out_nomodel_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_ARGMAX)) else $error("result without argmax");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r != S_IDLE) else $error("memory write while idle");

endmodule
`default_nettype wire

// ===== hw/rtl/bnbc_count_mem.sv =====
// Synchronous single-port-read, single-port-write memory for the bin counts.
// One row holds the counts of all classes for one pixel and bin; the read is registered.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bnbc_count_mem #(
  parameter int ADDR_W = 15,
  parameter int ROW_W = 160
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [ROW_W-1:0]  rdata,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [ROW_W-1:0]  wdata
);

  logic [ROW_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for binned_naive_bayes_classifier_core.
// Drives pixel transactions; compares each result with a bit-exact classifier model or a row's typed verdict.
// Depends on the core RTL and its package bnbc_pkg.
`timescale 1ns / 1ps
module testbench;

  localparam int CLASSES = 10;
  localparam int BINS = 32;
  localparam int PIXELS = 1024;
  localparam int CNT_MAX = 65535;
  localparam int CYCLE_LIMIT = 600000;
  localparam bit OP_TRAIN = 1'b0;
  localparam bit OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [3:0] label;
    logic signed [23:0] score;
    logic no_model;
  } verdict_t;

  typedef struct {
    bit op;
    bit [7:0] value;
    bit [9:0] index;
    bit [3:0] label;
    bit last;
    bit typed;
    verdict_t want;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  logic [15:0] hist[CLASSES][PIXELS][BINS];
  logic [15:0] image_count[CLASSES];
  int score_acc[CLASSES];
  int ppi;
  verdict_t pending_verdicts[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_off = 0;
  pixel_row_t rows[11];

  always #2 clk = ~clk;

  binned_naive_bayes_classifier_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic int log2q8(int unsigned x);
    int k;
    longint unsigned m;
    if (x == 0) return -3402;
    k = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = (longint'(x) << 8) >> k;
    return k * 256 + int'(m) - 256;
  endfunction

  function automatic int clamp24(longint s);
    if (s > 8388607) return 8388607;
    if (s < -8388608) return -8388608;
    return int'(s);
  endfunction

  function automatic bit classify_step(bit op, bit [7:0] value, bit [9:0] idx,
                                       bit [3:0] lab, bit last, output verdict_t v);
    int b;
    bit in_range;
    bit found;
    int best;
    int best_s;
    int s;
    b = int'(value) >> 3;
    in_range = idx < ppi;
    found = 0;
    best = 0;
    best_s = 0;
    v = '0;
    if (op == OP_TRAIN) begin
      if (lab >= CLASSES) return 0;
      if (in_range && hist[lab][idx][b] != CNT_MAX) hist[lab][idx][b]++;
      if (last && image_count[lab] != CNT_MAX) image_count[lab]++;
      return 0;
    end
    for (int c = 0; c < CLASSES; c++)
      if (image_count[c] != 0 && in_range)
        score_acc[c] = clamp24(longint'(score_acc[c]) + log2q8(32'(hist[c][idx][b]))
                               - log2q8(32'(image_count[c])));
    if (!last) return 0;
    for (int c = 0; c < CLASSES; c++) begin
      if (image_count[c] == 0) continue;
      s = clamp24(longint'(score_acc[c]) + log2q8(32'(image_count[c])));
      if (!found || s > best_s) begin
        found = 1;
        best = c;
        best_s = s;
      end
    end
    for (int c = 0; c < CLASSES; c++) score_acc[c] = 0;
    v.label = best[3:0];
    v.score = best_s[23:0];
    v.no_model = !found;
    return 1;
  endfunction

  task automatic send_pixel(bit op, bit [7:0] value, bit [9:0] idx, bit [3:0] lab,
                            bit last, bit typed, verdict_t want);
    int gap;
    verdict_t v;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(posedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
    end
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tlast <= last;
    in_tdata <= {2'b00, lab, idx, value};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    if (classify_step(op, value, idx, lab, last, v))
      pending_verdicts.push_back(typed ? want : v);
  endtask

  task automatic drain_and_config(int value);
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    ppi = value;
  endtask

  task automatic send_image(bit op, int len);
    bit [3:0] lab;
    bit [9:0] idx;
    bit [7:0] value;
    lab = 4'($urandom_range(0, CLASSES - 1));
    for (int i = 0; i < len; i++) begin
      idx = 10'((ppi <= 16) ? i : $urandom_range(0, ppi - 1));
      value = 8'(lab * 25 + $urandom_range(0, 30));
      send_pixel(op, value, idx, lab, i == len - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t exp_v;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (out_tvalid && out_tready) begin
      got.label = out_tdata[3:0];
      got.score = out_tdata[27:4];
      got.no_model = out_tuser;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (got.label !== exp_v.label || got.score !== exp_v.score ||
            got.no_model !== exp_v.no_model) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected label %0d score %0d no_model %0d, got %0d %0d %0d",
                     exp_v.label, exp_v.score, exp_v.no_model,
                     got.label, got.score, got.no_model);
        end
      end
    end
  end

  initial begin : receiver
    int w;
    forever begin
      if (hold_off > 0) begin
        repeat (hold_off) begin
          @(posedge clk);
          out_tready <= 1'b0;
        end
        hold_off = 0;
      end
      w = quiet ? 0 : $urandom_range(0, 7);
      repeat (w) begin
        @(posedge clk);
        out_tready <= 1'b0;
      end
      @(posedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int plan[7];
    int kind;
    int budget;
    for (int c = 0; c < CLASSES; c++) begin
      image_count[c] = '0;
      score_acc[c] = 0;
      for (int p = 0; p < PIXELS; p++)
        for (int b = 0; b < BINS; b++) hist[c][p][b] = '0;
    end
    ppi = 784;
    rows[0] = '{OP_CLASSIFY, 8'd0, 10'd0, 4'd0, 1'b1, 1'b1, '{4'd0, 24'sd0, 1'b1}};
    rows[1] = '{OP_TRAIN, 8'd0, 10'd0, 4'd0, 1'b0, 1'b0, '0};
    rows[2] = '{OP_TRAIN, 8'd255, 10'd783, 4'd0, 1'b1, 1'b0, '0};
    rows[3] = '{OP_TRAIN, 8'd128, 10'd5, 4'd9, 1'b1, 1'b0, '0};
    rows[4] = '{OP_TRAIN, 8'd7, 10'd0, 4'd15, 1'b1, 1'b0, '0};
    rows[5] = '{OP_TRAIN, 8'd200, 10'd800, 4'd2, 1'b1, 1'b0, '0};
    rows[6] = '{OP_CLASSIFY, 8'd0, 10'd0, 4'd0, 1'b0, 1'b0, '0};
    rows[7] = '{OP_CLASSIFY, 8'd255, 10'd783, 4'd0, 1'b0, 1'b0, '0};
    rows[8] = '{OP_CLASSIFY, 8'd100, 10'd1023, 4'd0, 1'b1, 1'b0, '0};
    rows[9] = '{OP_CLASSIFY, 8'd128, 10'd5, 4'd15, 1'b1, 1'b0, '0};
    rows[10] = '{OP_TRAIN, 8'd248, 10'd1000, 4'd9, 1'b0, 1'b0, '0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i])
      send_pixel(rows[i].op, rows[i].value, rows[i].index, rows[i].label,
                 rows[i].last, rows[i].typed, rows[i].want);

    plan = '{1, 1024, 6, 1023, 3, 13, 8};
    foreach (plan[p]) begin
      drain_and_config(plan[p]);
      quiet = (p == 2);
      budget = 120;
      if (p == 3) hold_off = 400;
      while (budget > 0) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          send_image(OP_TRAIN, (ppi <= 16) ? ppi : $urandom_range(1, 12));
          budget -= (ppi <= 16) ? ppi : 6;
        end else if (kind < 9) begin
          send_image(OP_CLASSIFY, (ppi <= 16) ? ppi : $urandom_range(1, 12));
          budget -= (ppi <= 16) ? ppi : 6;
        end else begin
          send_pixel(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)), 1'b0, '0);
          budget--;
        end
      end
    end
    quiet = 1'b0;
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/bnbc_pkg.sv
hw/rtl/bnbc_count_mem.sv
hw/rtl/binned_naive_bayes_classifier_core.sv
tb/sv/testbench.sv
